// ----- rtl/binary_to_decimal_ascii_digits_top_defines.svh -----
// Assertion macros used by the checker file.
`ifndef BINARY_TO_DECIMAL_ASCII_DIGITS_TOP_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DIGITS_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define B2D_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define B2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/b2d_pkg.sv -----
`timescale 1ns / 1ps
package b2d_pkg;

    localparam int NUM_W      = 32;
    localparam int CNT_IN_W   = 4;
    localparam int CHAR_W     = 6;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_IW     = $clog2(BCD_DIGITS);
    localparam int STEP_W     = $clog2(NUM_W);
    localparam int Q_DEPTH    = 2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_back_state;

endpackage

// ----- rtl/b2d_front.sv -----
`timescale 1ns / 1ps
module b2d_front #(
    parameter int MAX_DIGITS = 10,
    localparam int CW = $clog2(MAX_DIGITS + 1)
) (
    input  logic                         i_valid,
    input  logic [b2d_pkg::NUM_W-1:0]    i_number,
    input  logic [b2d_pkg::CNT_IN_W-1:0] i_digit_count,
    output logic                         o_stall,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output logic [b2d_pkg::NUM_W+CW-1:0] o_q_data
);

    localparam int XW = (CW > b2d_pkg::CNT_IN_W) ? CW : b2d_pkg::CNT_IN_W;

    logic [XW-1:0] w_cnt_x;
    logic [XW-1:0] w_clamp_x;

    // clamp to MAX_DIGITS; zero-count words produce nothing and are dropped here
    always_comb begin
        w_cnt_x   = XW'(i_digit_count);
        w_clamp_x = (w_cnt_x > XW'(MAX_DIGITS)) ? XW'(MAX_DIGITS) : w_cnt_x;
    end

    assign o_stall  = i_q_full;
    assign o_q_push = i_valid && !i_q_full && (w_cnt_x != '0);
    assign o_q_data = {i_number, w_clamp_x[CW-1:0]};

endmodule

// ----- rtl/b2d_fifo.sv -----
`timescale 1ns / 1ps
module b2d_fifo #(
    parameter int DW = 36
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);

    localparam int AW = $clog2(b2d_pkg::Q_DEPTH);
    localparam int NW = $clog2(b2d_pkg::Q_DEPTH + 1);

    logic [DW-1:0] r_mem [b2d_pkg::Q_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [NW-1:0] r_cnt;

    assign o_full  = (r_cnt == NW'(b2d_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(b2d_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(b2d_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- rtl/b2d_back.sv -----
`timescale 1ns / 1ps
module b2d_back #(
    parameter int MAX_DIGITS = 10,
    localparam int CW = $clog2(MAX_DIGITS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  logic [b2d_pkg::NUM_W-1:0]  i_q_number,
    input  logic [CW-1:0]              i_q_count,
    output logic                       o_q_pop,
    output logic                       o_valid,
    output logic [b2d_pkg::CHAR_W-1:0] o_digit_char,
    output logic                       o_last_digit,
    input  logic                       i_stall
);

    localparam int PW = (CW > b2d_pkg::BCD_IW) ? CW : b2d_pkg::BCD_IW;

    b2d_pkg::t_back_state r_state;
    b2d_pkg::t_back_state n_state;

    logic [b2d_pkg::NUM_W-1:0]  r_bin;
    logic [3:0]                 r_bcd [b2d_pkg::BCD_DIGITS];
    logic [3:0]                 n_bcd [b2d_pkg::BCD_DIGITS];
    logic [3:0]                 w_adj [b2d_pkg::BCD_DIGITS];
    logic [b2d_pkg::STEP_W-1:0] r_step;
    logic [CW-1:0]              r_pos;
    logic                       r_out_valid;
    logic [b2d_pkg::CHAR_W-1:0] r_char;
    logic                       r_last;
    logic                       w_load;
    logic [PW-1:0]              w_pos_x;
    logic [3:0]                 w_digit;

    // one double-dabble step: add 3 to digits of 5 or more, then shift left
    always_comb begin
        for (int i = 0; i < b2d_pkg::BCD_DIGITS; i++) begin
            w_adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
        n_bcd[0] = {w_adj[0][2:0], r_bin[b2d_pkg::NUM_W-1]};
        for (int i = 1; i < b2d_pkg::BCD_DIGITS; i++) begin
            n_bcd[i] = {w_adj[i][2:0], w_adj[i-1][3]};
        end
    end

    // positions above the tenth digit read as zero
    always_comb begin
        w_pos_x = PW'(r_pos);
        w_digit = '0;
        if (w_pos_x < PW'(b2d_pkg::BCD_DIGITS)) begin
            w_digit = r_bcd[w_pos_x[b2d_pkg::BCD_IW-1:0]];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            b2d_pkg::S_IDLE: begin
                if (i_q_valid) n_state = b2d_pkg::S_CONV;
            end
            b2d_pkg::S_CONV: begin
                if (r_step == b2d_pkg::STEP_W'(b2d_pkg::NUM_W - 1)) n_state = b2d_pkg::S_EMIT;
            end
            b2d_pkg::S_EMIT: begin
                if (w_load && (r_pos == '0)) n_state = b2d_pkg::S_IDLE;
            end
            default: n_state = b2d_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            b2d_pkg::S_IDLE: o_q_pop = i_q_valid;
            b2d_pkg::S_CONV: ;
            b2d_pkg::S_EMIT: w_load = !r_out_valid || !i_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= b2d_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_bin  <= i_q_number;
            r_pos  <= i_q_count - 1'b1;
            r_step <= '0;
            for (int i = 0; i < b2d_pkg::BCD_DIGITS; i++) begin
                r_bcd[i] <= '0;
            end
        end else if (r_state == b2d_pkg::S_CONV) begin
            r_bin  <= {r_bin[b2d_pkg::NUM_W-2:0], 1'b0};
            r_step <= r_step + 1'b1;
            r_bcd  <= n_bcd;
        end
        if (w_load) begin
            r_char <= b2d_pkg::ASCII_ZERO + {2'b00, w_digit};
            r_last <= (r_pos == '0);
            r_pos  <= r_pos - 1'b1;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_char;
    assign o_last_digit = r_last;

endmodule

// ----- rtl/binary_to_decimal_ascii_digits_top.sv -----
//  channel  dir  handshake          fields
//  in       in   i_valid / o_stall  i_number[31:0], i_digit_count[3:0]
//  out      out  o_valid / i_stall  o_digit_char[5:0], o_last_digit
//
//  Each word with a nonzero count is loaded into the double-dabble BCD
//  converter, shifted once per input bit, then sent one digit per cycle
//  while i_stall is low. Zero-count words are dropped at the front.
//  A two-entry queue takes new words while the converter is busy.
//  Reset is synchronous, active low; it empties the queue and output stage.
`timescale 1ns / 1ps
module binary_to_decimal_ascii_digits_top #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [b2d_pkg::NUM_W-1:0]    i_number,
    input  logic [b2d_pkg::CNT_IN_W-1:0] i_digit_count,
    output logic                         o_stall,
    output logic                         o_valid,
    output logic [b2d_pkg::CHAR_W-1:0]   o_digit_char,
    output logic                         o_last_digit,
    input  logic                         i_stall
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int DW = b2d_pkg::NUM_W + CW;

    logic          w_q_full;
    logic          w_q_push;
    logic [DW-1:0] w_q_wdata;
    logic          w_q_pop;
    logic          w_q_valid;
    logic [DW-1:0] w_q_rdata;

    b2d_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
        .i_valid       (i_valid),
        .i_number      (i_number),
        .i_digit_count (i_digit_count),
        .o_stall       (o_stall),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_q_data      (w_q_wdata)
    );

    b2d_fifo #(.DW(DW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_rdata)
    );

    b2d_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_number   (w_q_rdata[DW-1:CW]),
        .i_q_count    (w_q_rdata[CW-1:0]),
        .o_q_pop      (w_q_pop),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit),
        .i_stall      (i_stall)
    );

endmodule

// ----- rtl/b2d_checker.sv -----
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_digits_top_defines.svh"
module b2d_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic [b2d_pkg::NUM_W-1:0]    i_number,
    input logic [b2d_pkg::CNT_IN_W-1:0] i_digit_count,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic [b2d_pkg::CHAR_W-1:0]   o_digit_char,
    input logic                         o_last_digit,
    input logic                         i_stall
);

    `B2D_ASSERT_NEXT(a_in_hold, i_valid && o_stall, i_valid && $stable(i_number) && $stable(i_digit_count), "stalled input word changed")
    `B2D_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_digit_char) && $stable(o_last_digit), "stalled output word changed")
    `B2D_ASSERT_IMP(a_char_range, o_valid, (o_digit_char >= 6'd48) && (o_digit_char <= 6'd57), "digit character out of range")
    `B2D_ASSERT_NEXT(a_run_gapless, o_valid && !i_stall && !o_last_digit, o_valid, "gap inside a digit run")

endmodule

bind binary_to_decimal_ascii_digits_top b2d_checker u_b2d_checker (.*);

// ----- tb/tb_binary_to_decimal_ascii_digits_top.sv -----
`timescale 1ns / 1ps
module tb_binary_to_decimal_ascii_digits_top;

    localparam int MAX_DIGITS  = 10;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 80;

    typedef struct packed {
        logic [b2d_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } t_digit;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_valid;
    logic [b2d_pkg::NUM_W-1:0]    i_number;
    logic [b2d_pkg::CNT_IN_W-1:0] i_digit_count;
    logic                         o_stall;
    logic                         o_valid;
    logic [b2d_pkg::CHAR_W-1:0]   o_digit_char;
    logic                         o_last_digit;
    logic                         i_stall;

    t_digit pending_digits[$];
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_requests = 0;
    int     mismatches    = 0;
    int     words_sent    = 0;
    int     empty_words   = 0;
    int     clamped_words = 0;
    int     digits_seen   = 0;
    int     quiet_cycles  = 0;

    binary_to_decimal_ascii_digits_top #(
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_number     (i_number),
        .i_digit_count(i_digit_count),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit),
        .i_stall      (i_stall)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // number mod 10^count, spelled most significant digit first
    task automatic predict_digits(input logic [b2d_pkg::NUM_W-1:0] num,
                                  input logic [b2d_pkg::CNT_IN_W-1:0] cnt);
        logic [3:0]                dec[MAX_DIGITS];
        logic [b2d_pkg::NUM_W-1:0] rest;
        int                        n;
        t_digit                    d;
        rest = num;
        n = (cnt > MAX_DIGITS) ? MAX_DIGITS : int'(cnt);
        for (int k = 0; k < n; k++) begin
            dec[k] = 4'(rest % 10);
            rest   = rest / 10;
        end
        for (int k = n - 1; k >= 0; k--) begin
            d.ch   = b2d_pkg::ASCII_ZERO + b2d_pkg::CHAR_W'(dec[k]);
            d.last = (k == 0);
            pending_digits.push_back(d);
        end
    endtask

    // called right after a rising edge; returns at the edge that takes the word
    task automatic send_word(input logic [b2d_pkg::NUM_W-1:0] num,
                             input logic [b2d_pkg::CNT_IN_W-1:0] cnt);
        logic stalled;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_number      <= num;
        i_digit_count <= cnt;
        do begin
            @(negedge i_clk);
            stalled = o_stall;
            @(posedge i_clk);
        end while (stalled);
        predict_digits(num, cnt);
        words_sent++;
        if (cnt == 0)
            empty_words++;
        if (cnt > MAX_DIGITS)
            clamped_words++;
    endtask

    function automatic logic [b2d_pkg::NUM_W-1:0] pick_number();
        logic [b2d_pkg::NUM_W-1:0] p;
        p = 1;
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(0, 999);
            2: begin
                repeat ($urandom_range(9)) p = p * 10;
                return p + $urandom_range(2) - 1;
            end
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    function automatic logic [b2d_pkg::CNT_IN_W-1:0] pick_count();
        int r;
        r = $urandom_range(19);
        if (r < 2)
            return '0;
        if (r < 4)
            return b2d_pkg::CNT_IN_W'($urandom_range(11, 15));
        return b2d_pkg::CNT_IN_W'($urandom_range(1, 10));
    endfunction

    task automatic test_directed();
        send_word(32'd0, 4'd1);
        send_word(32'd0, 4'd10);
        send_word(32'hFFFF_FFFF, 4'd10);
        send_word(32'hFFFF_FFFF, 4'd1);
        send_word(32'hFFFF_FFFF, 4'd9);
        send_word(32'd12345, 4'd0);
        send_word(32'd1234567890, 4'd10);
        send_word(32'd123, 4'd15);
        send_word(32'hFFFF_FFFF, 4'd11);
        send_word(32'd9, 4'd1);
        send_word(32'd10, 4'd1);
        send_word(32'd1000000000, 4'd10);
        send_word(32'd999999999, 4'd10);
        send_word(32'd12345, 4'd3);
        send_word(32'd42, 4'd5);
        send_word(32'hAAAA_5555, 4'd12);
        send_word(32'h5555_AAAA, 4'd8);
        send_word(32'd7, 4'd0);
    endtask

    task automatic test_random(input int n);
        repeat (n) send_word(pick_number(), pick_count());
    endtask

    // receiver holds off while words keep coming, so the input backs up
    task automatic test_backpressure();
        i_valid <= 1'b0;
        @(negedge i_clk);
        hold_requests++;
        @(posedge i_clk);
        repeat (14)
            send_word(pick_number(), b2d_pkg::CNT_IN_W'($urandom_range(1, 15)));
    endtask

    initial begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(negedge i_clk) begin
        t_digit want;
        if (i_rst_n && o_valid && !i_stall) begin
            digits_seen++;
            if (pending_digits.size() == 0) begin
                report_mismatch($sformatf("unexpected digit char=%0d last=%0b",
                                          o_digit_char, o_last_digit));
            end else begin
                want = pending_digits.pop_front();
                if (o_digit_char !== want.ch)
                    report_mismatch($sformatf("digit char %0d, want %0d",
                                              o_digit_char, want.ch));
                if (o_last_digit !== want.last)
                    report_mismatch($sformatf("last flag %0b, want %0b",
                                              o_last_digit, want.last));
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", quiet_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_number      <= '0;
        i_digit_count <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        send_idle_pct = 14;
        recv_idle_pct = 79;
        test_random(80);
        send_idle_pct = 79;
        recv_idle_pct = 14;
        test_random(80);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(80);
        test_backpressure();

        i_valid <= 1'b0;
        recv_idle_pct = 0;
        while (pending_digits.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("sent %0d words (%0d empty, %0d over the digit limit), checked %0d digits",
                 words_sent, empty_words, clamped_words, digits_seen);
        $display("covered both sides idling, no idling, and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending_digits.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d digits never seen", mismatches,
                     pending_digits.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/b2d_pkg.sv
rtl/b2d_front.sv
rtl/b2d_fifo.sv
rtl/b2d_back.sv
rtl/binary_to_decimal_ascii_digits_top.sv
rtl/b2d_checker.sv
tb/tb_binary_to_decimal_ascii_digits_top.sv
